@@ src/imu_angle_frame_parser_core_macros.svh @@
// ----------------------------------------------------------------------------
// IMU angle frame parser assertion macros
// Shared concurrent assertion forms for the checker of the parser core.
// ----------------------------------------------------------------------------
`ifndef IMU_ANGLE_FRAME_PARSER_CORE_MACROS_SVH
`define IMU_ANGLE_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define IFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define IFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is asserted.
`define IFP_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ifp_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU angle frame parser package
// Frame constants, the scaled-angle width and the frame result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ifp_pkg;

    localparam int BYTE_W   = 8;
    localparam int RAW_W    = 16;
    localparam int ANGLE_W  = 24;
    localparam int N_ANGLE  = 3;
    localparam int N_ABYTES = 6;
    localparam int POS_W    = 4;
    localparam int OUT_W    = N_ANGLE * ANGLE_W;

    localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h55;
    localparam logic [BYTE_W-1:0] ANGLE_TYPE = 8'h53;
    localparam logic [POS_W-1:0]  POS_TYPE   = 4'd1;
    localparam logic [POS_W-1:0]  POS_FIRST  = 4'd2;
    localparam logic [POS_W-1:0]  POS_ALAST  = 4'd7;
    localparam logic [POS_W-1:0]  POS_CSUM   = 4'd10;

    // Frame parser states.
    localparam logic ST_HUNT  = 1'b0;
    localparam logic ST_FRAME = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    // One completed, checked frame: hit flag plus angle bytes 2..7.
    typedef struct packed {
        logic                      hit;
        t_byte [N_ABYTES-1:0]      abytes;
    } t_frame_result;

endpackage

@@ src/imu_angle_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// IMU angle frame parser core
// Parses 11-byte IMU angle frames from a byte stream into scaled angles.
// ----------------------------------------------------------------------------
// Each byte transfer on the slave side goes into an input register; the
// frame state machine consumes it from there and, on the checksum byte of a
// good frame, the scaled roll, pitch and yaw land in the output register.
// A frame starts with header 0x55, has type byte 0x53 at offset 1, angles as
// little-endian int16 at offsets 2/3, 4/5 and 6/7, and ends with an 8-bit
// additive checksum of offsets 0 to 9 at offset 10. Bad frames are dropped
// silently and the parser hunts for the next header. Angles are degrees
// times 32768, signed 24 bits (raw value times 180, exact). The core takes
// one byte per clock while the output is not stalled: a byte leaves the
// input register whenever the output register is empty or being read in
// the same cycle. The last byte of a frame passes through the input
// register, and its result is then held in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_angle_frame_parser_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Slave side: one received serial byte.
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [7:0]                i_s_axis_tdata,   // [7:0] rx_byte
    // Master side: one parsed angle frame.
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // [23:0] roll_angle, [47:24] pitch_angle, [71:48] yaw_angle
    output logic [ifp_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import ifp_pkg::*;

    logic                  r_in_valid;
    t_byte                 r_in_byte;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic                  w_advance;
    logic                  w_fire;
    t_frame_result         w_result;
    logic signed [N_ANGLE-1:0][ANGLE_W-1:0] w_angles;

    // The output register can take a new result when it is empty or its
    // current result is being transferred in this cycle.
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_advance;
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    ifp_frame_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    ifp_angle_scale u_scale (
        .i_abytes (w_result.abytes),
        .o_angles (w_angles)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_result.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.hit) begin
            r_out_data <= w_angles;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

@@ src/ifp_frame_fsm.sv @@
// ----------------------------------------------------------------------------
// IMU angle frame parser state machine
// Hunts for the header, collects the frame body and checks type and sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifp_frame_fsm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  ifp_pkg::t_byte        i_byte,
    output ifp_pkg::t_frame_result o_result
);
    import ifp_pkg::*;

    logic                 r_state, n_state;
    logic [POS_W-1:0]     r_pos, n_pos;
    t_byte                r_sum, n_sum;
    logic                 r_type_ok, n_type_ok;
    t_byte [N_ABYTES-1:0] r_abytes;
    logic                 w_store;
    logic [2:0]           w_aidx;

    assign w_aidx  = r_pos[2:0] - POS_FIRST[2:0];
    assign w_store = i_fire && (r_state == ST_FRAME) && (r_pos >= POS_FIRST)
                     && (r_pos <= POS_ALAST);

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_type_ok = r_type_ok;
        unique case (r_state)
            ST_HUNT: begin
                if (i_byte == HDR_BYTE) begin
                    n_state   = ST_FRAME;
                    n_pos     = POS_TYPE;
                    n_sum     = HDR_BYTE;
                    n_type_ok = 1'b0;
                end
            end
            ST_FRAME: begin
                if (r_pos >= POS_CSUM) begin
                    n_state = ST_HUNT;
                    n_pos   = '0;
                end else begin
                    if (r_pos <= POS_TYPE) begin
                        n_type_ok = (i_byte == ANGLE_TYPE);
                    end
                    n_sum = r_sum + i_byte;
                    n_pos = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HUNT;
            r_pos     <= '0;
            r_sum     <= '0;
            r_type_ok <= 1'b0;
        end else if (i_fire) begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_type_ok <= n_type_ok;
        end
    end

    // Angle byte store holds payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_abytes[w_aidx] <= i_byte;
        end
    end

    // The checksum byte closes a good frame when type and sum both match.
    assign o_result.hit    = i_fire && (r_state == ST_FRAME) && (r_pos >= POS_CSUM)
                             && r_type_ok && (r_sum == i_byte);
    assign o_result.abytes = r_abytes;

endmodule

@@ src/ifp_angle_scale.sv @@
// ----------------------------------------------------------------------------
// IMU angle frame parser angle scaler
// Forms three little-endian int16 angles and multiplies each by 180.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifp_angle_scale (
    input  ifp_pkg::t_byte [ifp_pkg::N_ABYTES-1:0]                   i_abytes,
    output logic signed [ifp_pkg::N_ANGLE-1:0][ifp_pkg::ANGLE_W-1:0] o_angles
);
    import ifp_pkg::*;

    logic signed [RAW_W-1:0]   w_raw [N_ANGLE];
    logic signed [ANGLE_W-1:0] w_ext [N_ANGLE];

    // 180 = 128 + 32 + 16 + 4, so the product is four shifted adds.
    always_comb begin
        for (int k = 0; k < N_ANGLE; k++) begin
            w_raw[k]    = {i_abytes[2*k+1], i_abytes[2*k]};
            w_ext[k]    = ANGLE_W'(w_raw[k]);
            o_angles[k] = (w_ext[k] <<< 7) + (w_ext[k] <<< 5)
                          + (w_ext[k] <<< 4) + (w_ext[k] <<< 2);
        end
    end

endmodule

@@ src/ifp_checker.sv @@
// ----------------------------------------------------------------------------
// IMU angle frame parser checker
// Port-level assertions on the parser core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "imu_angle_frame_parser_core_macros.svh"

module ifp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic [7:0]                i_s_axis_tdata,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [ifp_pkg::OUT_W-1:0] o_m_axis_tdata
);

    // A stalled result keeps its valid and its angles.
    `IFP_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // Reset empties the output register.
    `IFP_ASSERT_NEXT_ALWAYS(a_rst_empty, !i_rst_n, !o_m_axis_tvalid, "result valid after reset")

    // With no result waiting, the core always takes a byte.
    `IFP_ASSERT_SAME(a_ready_when_empty, !o_m_axis_tvalid, o_s_axis_tready, "input stalled while output empty")

    // A fresh result follows an earlier byte transfer on the slave side.
    `IFP_ASSERT_SAME(a_out_cause, $rose(o_m_axis_tvalid), $past(i_s_axis_tvalid && o_s_axis_tready, 2), "result without input transfer")

endmodule

bind imu_angle_frame_parser_core ifp_checker u_ifp_checker (.*);
